// File: hw/rtl/vbfg_pkg.sv
// ============================================================================
// vbfg_pkg
// Shared types, field widths, request codes and register map of the voxel
// block fill grid unit.
// ============================================================================
`timescale 1ns / 1ps

package vbfg_pkg;

    localparam int IDX_W     = 16;
    localparam int SIZE_W    = 7;
    localparam int EDGE_W    = 4;
    localparam int MODE_W    = 2;
    localparam int ADDR_W    = 21;
    localparam int T_W       = 15;
    localparam int STEP_W    = 2 * SIZE_W;
    localparam int WORD_W    = 64;
    localparam int BIT_W     = 6;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 4;
    localparam int REG_SEL_W = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MARK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    localparam logic [REG_SEL_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [REG_SEL_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [REG_SEL_W-1:0] REG_SIZE_Z = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0] lo;
        logic [SIZE_W-1:0] hi;
        logic              outside;
        logic              in_grid;
    } axis_clip_t;

    function automatic axis_clip_t clip_axis(
        input logic signed [IDX_W-1:0] pos,
        input logic [EDGE_W-1:0]       e,
        input logic [SIZE_W-1:0]       len
    );
        logic signed [IDX_W+1:0] p;
        logic signed [IDX_W+1:0] edge_len;
        logic signed [IDX_W+1:0] last;
        logic signed [IDX_W+1:0] lim;
        logic signed [IDX_W+1:0] lo;
        logic signed [IDX_W+1:0] hi;
        axis_clip_t              r;
        p        = (IDX_W+2)'(pos);
        edge_len = (IDX_W+2)'(1) << e;
        last     = p + edge_len - (IDX_W+2)'(1);
        lim      = signed'((IDX_W+2)'(len)) - (IDX_W+2)'(1);
        lo       = (p < 0) ? '0 : p;
        hi       = (last < lim) ? last : lim;
        r.outside = (lo > hi);
        r.in_grid = (p >= 0) && (p <= lim);
        r.lo      = lo[SIZE_W-1:0];
        r.hi      = hi[SIZE_W-1:0];
        return r;
    endfunction

endpackage

// File: hw/rtl/voxel_block_fill_grid_unit.sv
// ============================================================================
// voxel_block_fill_grid_unit
// Dense 3D occupancy bit grid in a 64-bit wide synchronous memory. Mark
// requests clip a power-of-two cube to the grid and set one cell per cycle
// by read-modify-write, read requests return one cell, clear requests zero
// the grid one word per cycle.
// Flagged marks, out-of-grid reads and unknown modes finish from the clip
//   state without touching the memory.
// Throughput: one request at a time; the cell walk over the memory's separate
//   read and write ports sets the mark rate at one cell per cycle.
// Reset: config sizes go to 64, then a clearing pass over every word of the grid
//   holds busy high. done cannot be stalled.
// ============================================================================
`timescale 1ns / 1ps

module voxel_block_fill_grid_unit
    import vbfg_pkg::*;
#(
    parameter int AXIS_MAX   = 64,
    parameter int GRID_CELLS = 262144
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    output logic                    done,
    input  logic [MODE_W-1:0]       mode,
    input  logic signed [IDX_W-1:0] index_x,
    input  logic signed [IDX_W-1:0] index_y,
    input  logic signed [IDX_W-1:0] index_z,
    input  logic [EDGE_W-1:0]       edge_log2,
    output logic                    cell_occupied,
    output logic                    leaf_outside,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    localparam int WORDS = (GRID_CELLS + WORD_W - 1) / WORD_W;
    localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [WW-1:0]     LAST_WORD = WW'(WORDS - 1);
    localparam logic [SIZE_W-1:0] AXIS_LIM  = SIZE_W'(AXIS_MAX);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_CLIP   = 4'd2;
    localparam logic [3:0] S_MUL1   = 4'd3;
    localparam logic [3:0] S_MUL2   = 4'd4;
    localparam logic [3:0] S_WALK   = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_RDISS  = 4'd7;
    localparam logic [3:0] S_RDWAIT = 4'd8;

    // control
    logic [3:0]        state_reg, state_next;
    logic              done_reg, done_next;
    logic              occ_reg, occ_next;
    logic              outside_reg, outside_next;
    logic              clr_report_reg, clr_report_next;
    logic [WW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic              b_valid_reg, b_valid_next;
    logic              fwd_valid_reg, fwd_valid_next;
    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;

    // payload
    logic [MODE_W-1:0]       mode_reg, mode_next;
    logic signed [IDX_W-1:0] pos_x_reg, pos_x_next;
    logic signed [IDX_W-1:0] pos_y_reg, pos_y_next;
    logic signed [IDX_W-1:0] pos_z_reg, pos_z_next;
    logic [EDGE_W-1:0]       edge_reg, edge_next;
    logic [SIZE_W-1:0]       lo_x_reg, lo_x_next;
    logic [SIZE_W-1:0]       lo_y_reg, lo_y_next;
    logic [SIZE_W-1:0]       lo_z_reg, lo_z_next;
    logic [SIZE_W-1:0]       hi_x_reg, hi_x_next;
    logic [SIZE_W-1:0]       hi_y_reg, hi_y_next;
    logic [SIZE_W-1:0]       hi_z_reg, hi_z_next;
    logic [SIZE_W-1:0]       cx_reg, cx_next;
    logic [SIZE_W-1:0]       cy_reg, cy_next;
    logic [SIZE_W-1:0]       cz_reg, cz_next;
    logic [T_W-1:0]          t_reg, t_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [ADDR_W-1:0]       row_reg, row_next;
    logic [ADDR_W-1:0]       plane_reg, plane_next;
    logic [WW-1:0]           b_word_reg, b_word_next;
    logic [BIT_W-1:0]        b_bit_reg, b_bit_next;
    logic                    rd_ok_reg, rd_ok_next;
    logic [WW-1:0]           fwd_word_reg, fwd_word_next;
    logic [WORD_W-1:0]       fwd_data_reg, fwd_data_next;

    // memory
    logic [WORD_W-1:0] mem [WORDS];
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_en;
    logic [WW-1:0]     rd_word;
    logic              wr_en;
    logic [WW-1:0]     wr_word;
    logic [WORD_W-1:0] wr_data;

    logic [SIZE_W-1:0]        len_x, len_y, len_z;
    axis_clip_t               cl_x, cl_y, cl_z;
    logic [STEP_W-1:0]        mul_yz;
    logic [STEP_W-1:0]        mul_xy;
    logic [SIZE_W+T_W-1:0]    mul_row;
    logic [ADDR_W-1:0]        cur_addr;
    logic [ADDR_W-1:0]        step_ext;
    logic                     in_store;
    logic [WW-1:0]            cur_word;
    logic [WORD_W-1:0]        merged;
    logic [WORD_W-1:0]        set_data;
    logic                     walk_last;
    logic                     cfg_wr;
    logic [REG_SEL_W-1:0]     reg_sel;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[PADDR_W-1:2];

    always_comb
    begin
        unique case (reg_sel)
            REG_SIZE_X: prdata = DATA_W'(size_x_reg);
            REG_SIZE_Y: prdata = DATA_W'(size_y_reg);
            REG_SIZE_Z: prdata = DATA_W'(size_z_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_RESET;
            size_y_reg <= SIZE_RESET;
            size_z_reg <= SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            if (reg_sel == REG_SIZE_X)
            begin
                size_x_reg <= pwdata[SIZE_W-1:0];
            end
            if (reg_sel == REG_SIZE_Y)
            begin
                size_y_reg <= pwdata[SIZE_W-1:0];
            end
            if (reg_sel == REG_SIZE_Z)
            begin
                size_z_reg <= pwdata[SIZE_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    assign len_x = (int'(size_x_reg) > AXIS_MAX) ? AXIS_LIM : size_x_reg;
    assign len_y = (int'(size_y_reg) > AXIS_MAX) ? AXIS_LIM : size_y_reg;
    assign len_z = (int'(size_z_reg) > AXIS_MAX) ? AXIS_LIM : size_z_reg;

    assign cl_x = clip_axis(pos_x_reg, edge_reg, len_x);
    assign cl_y = clip_axis(pos_y_reg, edge_reg, len_y);
    assign cl_z = clip_axis(pos_z_reg, edge_reg, len_z);

    assign mul_yz  = len_y * lo_z_reg;
    assign mul_xy  = len_x * len_y;
    assign mul_row = len_x * t_reg;

    assign cur_addr  = row_reg + ADDR_W'(cx_reg);
    assign step_ext  = ADDR_W'(step_reg);
    assign in_store  = (32'(cur_addr) < 32'(GRID_CELLS));
    assign cur_word  = WW'(cur_addr >> BIT_W);
    assign walk_last = (cx_reg == hi_x_reg) && (cy_reg == hi_y_reg) && (cz_reg == hi_z_reg);

    // forward the word written last cycle: the read issued then saw old data
    assign merged   = (fwd_valid_reg && (fwd_word_reg == b_word_reg)) ? fwd_data_reg
                                                                       : rd_data_reg;
    assign set_data = merged | (WORD_W'(1) << b_bit_reg);

    assign rd_en   = ((state_reg == S_WALK) || (state_reg == S_RDISS)) && in_store;
    assign rd_word = cur_word;
    assign wr_en   = b_valid_reg || (state_reg == S_CLEAR);
    assign wr_word = (state_reg == S_CLEAR) ? clr_cnt_reg : b_word_reg;
    assign wr_data = (state_reg == S_CLEAR) ? '0 : set_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_word] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_word];
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        done_next       = 1'b0;
        occ_next        = 1'b0;
        outside_next    = 1'b0;
        clr_report_next = clr_report_reg;
        clr_cnt_next    = clr_cnt_reg;
        b_valid_next    = 1'b0;
        fwd_valid_next  = b_valid_reg;
        fwd_word_next   = b_word_reg;
        fwd_data_next   = set_data;
        mode_next       = mode_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        pos_z_next      = pos_z_reg;
        edge_next       = edge_reg;
        lo_x_next       = lo_x_reg;
        lo_y_next       = lo_y_reg;
        lo_z_next       = lo_z_reg;
        hi_x_next       = hi_x_reg;
        hi_y_next       = hi_y_reg;
        hi_z_next       = hi_z_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        t_next          = t_reg;
        step_next       = step_reg;
        row_next        = row_reg;
        plane_next      = plane_reg;
        b_word_next     = b_word_reg;
        b_bit_next      = b_bit_reg;
        rd_ok_next      = rd_ok_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = mode;
                    pos_x_next = index_x;
                    pos_y_next = index_y;
                    pos_z_next = index_z;
                    edge_next  = edge_log2;
                    if (mode == MODE_CLEAR)
                    begin
                        clr_cnt_next    = '0;
                        clr_report_next = 1'b1;
                        state_next      = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_CLIP;
                    end
                end
            end
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + WW'(1);
                if (clr_cnt_reg == LAST_WORD)
                begin
                    done_next  = clr_report_reg;
                    state_next = S_IDLE;
                end
            end
            S_CLIP:
            begin
                lo_x_next = cl_x.lo;
                lo_y_next = cl_y.lo;
                lo_z_next = cl_z.lo;
                hi_x_next = cl_x.hi;
                hi_y_next = cl_y.hi;
                hi_z_next = cl_z.hi;
                cx_next   = cl_x.lo;
                cy_next   = cl_y.lo;
                cz_next   = cl_z.lo;
                unique case (mode_reg)
                    MODE_MARK:
                    begin
                        if (cl_x.outside || cl_y.outside || cl_z.outside)
                        begin
                            done_next    = 1'b1;
                            outside_next = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_MUL1;
                        end
                    end
                    MODE_READ:
                    begin
                        if (cl_x.in_grid && cl_y.in_grid && cl_z.in_grid)
                        begin
                            state_next = S_MUL1;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_MUL1:
            begin
                t_next     = T_W'(mul_yz) + T_W'(lo_y_reg);
                step_next  = mul_xy;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                row_next   = ADDR_W'(mul_row);
                plane_next = ADDR_W'(mul_row);
                state_next = (mode_reg == MODE_READ) ? S_RDISS : S_WALK;
            end
            S_WALK:
            begin
                b_valid_next = in_store;
                b_word_next  = cur_word;
                b_bit_next   = cur_addr[BIT_W-1:0];
                if (cx_reg == hi_x_reg)
                begin
                    cx_next = lo_x_reg;
                    if (cy_reg == hi_y_reg)
                    begin
                        cy_next    = lo_y_reg;
                        cz_next    = cz_reg + SIZE_W'(1);
                        plane_next = plane_reg + step_ext;
                        row_next   = plane_reg + step_ext;
                    end
                    else
                    begin
                        cy_next  = cy_reg + SIZE_W'(1);
                        row_next = row_reg + ADDR_W'(len_x);
                    end
                end
                else
                begin
                    cx_next = cx_reg + SIZE_W'(1);
                end
                if (walk_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_RDISS:
            begin
                rd_ok_next = in_store;
                b_bit_next = cur_addr[BIT_W-1:0];
                state_next = S_RDWAIT;
            end
            S_RDWAIT:
            begin
                done_next  = 1'b1;
                occ_next   = rd_ok_reg & rd_data_reg[b_bit_reg];
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            done_reg       <= 1'b0;
            occ_reg        <= 1'b0;
            outside_reg    <= 1'b0;
            clr_report_reg <= 1'b0;
            clr_cnt_reg    <= '0;
            b_valid_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            occ_reg        <= occ_next;
            outside_reg    <= outside_next;
            clr_report_reg <= clr_report_next;
            clr_cnt_reg    <= clr_cnt_next;
            b_valid_reg    <= b_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        pos_x_reg    <= pos_x_next;
        pos_y_reg    <= pos_y_next;
        pos_z_reg    <= pos_z_next;
        edge_reg     <= edge_next;
        lo_x_reg     <= lo_x_next;
        lo_y_reg     <= lo_y_next;
        lo_z_reg     <= lo_z_next;
        hi_x_reg     <= hi_x_next;
        hi_y_reg     <= hi_y_next;
        hi_z_reg     <= hi_z_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        t_reg        <= t_next;
        step_reg     <= step_next;
        row_reg      <= row_next;
        plane_reg    <= plane_next;
        b_word_reg   <= b_word_next;
        b_bit_reg    <= b_bit_next;
        rd_ok_reg    <= rd_ok_next;
        fwd_word_reg <= fwd_word_next;
        fwd_data_reg <= fwd_data_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign cell_occupied = occ_reg;
    assign leaf_outside  = outside_reg;

endmodule

// File: hw/rtl/vbfg_check.sv
// ============================================================================
// vbfg_check
// Port-level checks on the request and result timing of the voxel block
// fill grid unit, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps

module vbfg_check
    import vbfg_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    done,
    input logic [MODE_W-1:0]       mode,
    input logic signed [IDX_W-1:0] index_x,
    input logic                    cell_occupied,
    input logic                    leaf_outside
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted request");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_quiet_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (!cell_occupied && !leaf_outside))
        else $error("result fields active without strobe");

    a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_NONE)
            |=> ##1 (done && !cell_occupied && !leaf_outside))
        else $error("unused mode did not return an empty result");

    a_read_negative: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_READ && index_x[IDX_W-1])
            |=> ##1 (done && !cell_occupied))
        else $error("read below grid did not return zero");

endmodule

bind voxel_block_fill_grid_unit vbfg_check u_vbfg_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .mode          (mode),
    .index_x       (index_x),
    .cell_occupied (cell_occupied),
    .leaf_outside  (leaf_outside)
);

// File: dv/voxel_block_fill_grid_unit_tb.sv
// ============================================================================
// voxel_block_fill_grid_unit_tb
// Self-checking bench for the voxel block fill grid unit. A queue-fed driver
// issues clear, mark, read and unused-mode requests with random gaps. A local
// occupancy grid predicts each result, and a monitor compares every done
// strobe against the oldest prediction. Grid sizes are reprogrammed over APB
// between phases, from small grids through zero and oversized axes.
// ============================================================================
`timescale 1ns / 1ps

module voxel_block_fill_grid_unit_tb;
    import vbfg_pkg::*;

    localparam int AXIS_MAX   = 64;
    localparam int GRID_CELLS = 262144;
    localparam int PHASES     = 10;
    localparam int PHASE_REQS = 142;

    localparam logic [REG_SEL_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic signed [IDX_W-1:0] ix;
        logic signed [IDX_W-1:0] iy;
        logic signed [IDX_W-1:0] iz;
        logic [EDGE_W-1:0]       edge_lg;
    } grid_request_t;

    typedef struct packed {
        logic occupied;
        logic outside;
    } cell_result_t;

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    start     = 1'b0;
    logic                    busy;
    logic                    done;
    logic [MODE_W-1:0]       mode      = MODE_NONE;
    logic signed [IDX_W-1:0] index_x   = '0;
    logic signed [IDX_W-1:0] index_y   = '0;
    logic signed [IDX_W-1:0] index_z   = '0;
    logic [EDGE_W-1:0]       edge_log2 = '0;
    logic                    cell_occupied;
    logic                    leaf_outside;
    logic                    psel      = 1'b0;
    logic                    penable   = 1'b0;
    logic                    pwrite    = 1'b0;
    logic [PADDR_W-1:0]      paddr     = '0;
    logic [DATA_W-1:0]       pwdata    = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;

    bit            grid_bits [GRID_CELLS];
    int            size_reg [3];
    grid_request_t request_queue [$];
    cell_result_t  awaited_results [$];
    grid_request_t active_req;
    cell_result_t  want;
    int            idle_left;
    bit            steady;
    int            queued_count;
    int            accepted_count;
    int            mode_seen [4];
    int            results_checked;
    int            occupied_reads;
    int            flagged_marks;
    int            mismatch_count;

    voxel_block_fill_grid_unit #(
        .AXIS_MAX   (AXIS_MAX),
        .GRID_CELLS (GRID_CELLS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .done          (done),
        .mode          (mode),
        .index_x       (index_x),
        .index_y       (index_y),
        .index_z       (index_z),
        .edge_log2     (edge_log2),
        .cell_occupied (cell_occupied),
        .leaf_outside  (leaf_outside),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int axis_cells(input int a);
        return (size_reg[a] > AXIS_MAX) ? AXIS_MAX : size_reg[a];
    endfunction

    function automatic bit clip_span(input int pos, input int lg, input int len,
                                     output int lo, output int hi);
        int last;
        last = pos + (1 << lg) - 1;
        lo   = (pos < 0) ? 0 : pos;
        hi   = (last < len - 1) ? last : len - 1;
        return lo <= hi;
    endfunction

    function automatic cell_result_t apply_to_grid(input grid_request_t q);
        cell_result_t res;
        int           pos [3];
        int           len [3];
        int           lo [3];
        int           hi [3];
        bit           in_grid;
        res    = '0;
        pos[0] = int'(q.ix);
        pos[1] = int'(q.iy);
        pos[2] = int'(q.iz);
        for (int a = 0; a < 3; a++)
            len[a] = axis_cells(a);
        case (q.mode)
            MODE_CLEAR:
            begin
                for (int i = 0; i < GRID_CELLS; i++)
                    grid_bits[i] = 1'b0;
            end
            MODE_MARK:
            begin
                in_grid = 1'b1;
                for (int a = 0; a < 3; a++)
                    if (!clip_span(pos[a], int'(q.edge_lg), len[a], lo[a], hi[a]))
                        in_grid = 1'b0;
                if (!in_grid)
                    res.outside = 1'b1;
                else
                    for (int z = lo[2]; z <= hi[2]; z++)
                        for (int y = lo[1]; y <= hi[1]; y++)
                            for (int x = lo[0]; x <= hi[0]; x++)
                                grid_bits[x + len[0] * (y + len[1] * z)] = 1'b1;
            end
            MODE_READ:
            begin
                in_grid = 1'b1;
                for (int a = 0; a < 3; a++)
                    if (pos[a] < 0 || pos[a] >= len[a])
                        in_grid = 1'b0;
                if (in_grid)
                    res.occupied = grid_bits[pos[0] + len[0] * (pos[1] + len[1] * pos[2])];
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic int wide_index();
        return int'($signed(16'($urandom())));
    endfunction

    function automatic void queue_request(input logic [MODE_W-1:0] m, input int x, input int y,
                                          input int z, input int lg);
        grid_request_t q;
        q.mode    = m;
        q.ix      = IDX_W'(x);
        q.iy      = IDX_W'(y);
        q.iz      = IDX_W'(z);
        q.edge_lg = EDGE_W'(lg);
        request_queue.push_back(q);
        queued_count++;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 200);
    endfunction

    function automatic int pick_edge();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return $urandom_range(0, 1);
        if (r < 75)
            return $urandom_range(2, 3);
        if (r < 90)
            return $urandom_range(4, 6);
        return $urandom_range(7, 15);
    endfunction

    function automatic int pick_corner(input int lg, input int len);
        int reach;
        int r;
        reach = (lg > 6) ? AXIS_MAX : (1 << lg);
        r     = $urandom_range(0, 99);
        if (r < 80)
            return int'($urandom_range(0, len + reach)) - reach;
        if (r < 90)
            return len - 1 - int'($urandom_range(0, 3));
        return wide_index();
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size(input int kind);
        int r;
        r = $urandom_range(0, 9);
        if (kind == 0)
            return SIZE_W'($urandom_range(1, 16));
        if (kind == 2)
            return SIZE_RESET;
        case (r)
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd2;
            3:       return 7'd63;
            4:       return 7'd64;
            5:       return 7'd65;
            6:       return 7'd127;
            default: return SIZE_W'($urandom_range(3, 32));
        endcase
    endfunction

    // Mark requests are followed now and then by reads inside the clipped cube.
    function automatic int queue_random_item();
        int r;
        int e;
        int cells;
        int n;
        int len;
        int pos [3];
        int lo [3];
        int hi [3];
        r = $urandom_range(0, 999);
        if (r < 8)
        begin
            queue_request(MODE_CLEAR, wide_index(), wide_index(), wide_index(),
                          $urandom_range(0, 15));
            return 1;
        end
        if (r < 40)
        begin
            queue_request(MODE_NONE, wide_index(), wide_index(), wide_index(),
                          $urandom_range(0, 15));
            return 1;
        end
        if (r < 520)
        begin
            do
            begin
                e     = pick_edge();
                cells = 1;
                for (int a = 0; a < 3; a++)
                begin
                    pos[a] = pick_corner(e, axis_cells(a));
                    if (clip_span(pos[a], e, axis_cells(a), lo[a], hi[a]))
                        cells = cells * (hi[a] - lo[a] + 1);
                    else
                        cells = 0;
                end
            end
            while (cells > 4096 || (cells > 512 && $urandom_range(0, 7) != 0));
            queue_request(MODE_MARK, pos[0], pos[1], pos[2], e);
            if (cells == 0 || $urandom_range(0, 1) == 0)
                return 1;
            n = $urandom_range(1, 2);
            for (int k = 0; k < n; k++)
                queue_request(MODE_READ, $urandom_range(lo[0], hi[0]),
                              $urandom_range(lo[1], hi[1]), $urandom_range(lo[2], hi[2]),
                              $urandom_range(0, 15));
            return n + 1;
        end
        for (int a = 0; a < 3; a++)
        begin
            len = axis_cells(a);
            if (r < 840 || $urandom_range(0, 2) == 0)
                pos[a] = (len == 0) ? 0 : $urandom_range(0, len - 1);
            else
                case ($urandom_range(0, 2))
                    0:       pos[a] = -1;
                    1:       pos[a] = len;
                    default: pos[a] = wide_index();
                endcase
        end
        queue_request(MODE_READ, pos[0], pos[1], pos[2], $urandom_range(0, 15));
        return 1;
    endfunction

    task automatic set_size(input logic [REG_SEL_W-1:0] sel, input logic [SIZE_W-1:0] val);
        logic [DATA_W-1:0] word;
        word              = $urandom_range(0, 1) ? DATA_W'($urandom()) : '0;
        word[SIZE_W-1:0]  = val;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_SIZE_X: size_reg[0] = int'(val);
            REG_SIZE_Y: size_reg[1] = int'(val);
            REG_SIZE_Z: size_reg[2] = int'(val);
            default:
            begin
            end
        endcase
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (accepted_count != queued_count || awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Driver: hold a request until accepted, then idle for a random gap.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            idle_left  = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                awaited_results.push_back(apply_to_grid(active_req));
                accepted_count++;
                mode_seen[active_req.mode]++;
                idle_left = pick_gap();
            end
            if (!(start && busy))
            begin
                if (idle_left > 0)
                begin
                    start     <= 1'b0;
                    idle_left  = idle_left - 1;
                end
                else if (request_queue.size() > 0)
                begin
                    active_req  = request_queue.pop_front();
                    mode       <= active_req.mode;
                    index_x    <= active_req.ix;
                    index_y    <= active_req.iy;
                    index_z    <= active_req.iz;
                    edge_log2  <= active_req.edge_lg;
                    start      <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with no request outstanding: occupied %0b outside %0b",
                         $time, cell_occupied, leaf_outside);
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (cell_occupied !== want.occupied)
                begin
                    $display("%0t: cell_occupied expected %0b actual %0b",
                             $time, want.occupied, cell_occupied);
                    mismatch_count++;
                end
                if (leaf_outside !== want.outside)
                begin
                    $display("%0t: leaf_outside expected %0b actual %0b",
                             $time, want.outside, leaf_outside);
                    mismatch_count++;
                end
                results_checked++;
                if (want.occupied)
                    occupied_reads++;
                if (want.outside)
                    flagged_marks++;
            end
        end
    end

    initial
    begin
        int pushed;
        for (int a = 0; a < 3; a++)
            size_reg[a] = int'(SIZE_RESET);
        for (int i = 0; i < GRID_CELLS; i++)
            grid_bits[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        set_size(REG_SIZE_X, 7'd64);
        set_size(REG_SIZE_Y, 7'd64);
        set_size(REG_SIZE_Z, 7'd64);
        set_size(REG_SPARE, 7'd5);
        queue_request(MODE_READ, 0, 0, 0, 15);
        queue_request(MODE_MARK, 0, 0, 0, 0);
        queue_request(MODE_READ, 0, 0, 0, 0);
        queue_request(MODE_MARK, -32768, -32768, -32768, 15);
        queue_request(MODE_MARK, 32767, 32767, 32767, 0);
        queue_request(MODE_MARK, 62, 62, 62, 15);
        queue_request(MODE_READ, 63, 63, 63, 0);
        queue_request(MODE_READ, 61, 63, 63, 0);
        queue_request(MODE_MARK, -3, 10, 20, 2);
        queue_request(MODE_READ, 0, 13, 23, 0);
        queue_request(MODE_READ, -1, 0, 0, 0);
        queue_request(MODE_READ, 64, 0, 0, 0);
        queue_request(MODE_READ, 0, 0, 64, 0);
        queue_request(MODE_READ, 32767, -32768, 0, 0);
        queue_request(MODE_NONE, 63, 63, 63, 15);
        queue_request(MODE_READ, 63, 63, 63, 0);
        queue_request(MODE_CLEAR, 0, 0, 0, 0);
        queue_request(MODE_READ, 63, 63, 63, 0);
        wait_idle();

        set_size(REG_SIZE_X, 7'd1);
        set_size(REG_SIZE_Y, 7'd1);
        set_size(REG_SIZE_Z, 7'd1);
        queue_request(MODE_MARK, -5, -5, -5, 15);
        queue_request(MODE_READ, 0, 0, 0, 0);
        queue_request(MODE_READ, 1, 0, 0, 0);
        wait_idle();

        set_size(REG_SIZE_X, 7'd0);
        set_size(REG_SIZE_Y, 7'd127);
        set_size(REG_SIZE_Z, 7'd2);
        queue_request(MODE_MARK, 0, 0, 0, 3);
        queue_request(MODE_READ, 0, 0, 0, 0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            if (ph == 0 || $urandom_range(0, 2) != 0)
                set_size(REG_SIZE_X, pick_size(ph % 3));
            if (ph == 0 || $urandom_range(0, 2) != 0)
                set_size(REG_SIZE_Y, pick_size(ph % 3));
            if (ph == 0 || $urandom_range(0, 2) != 0)
                set_size(REG_SIZE_Z, pick_size(ph % 3));
            if ($urandom_range(0, 3) == 0)
                set_size(REG_SPARE, SIZE_W'($urandom()));
            steady = ($urandom_range(0, 3) == 0);
            pushed = 0;
            if ($urandom_range(0, 1) == 0)
            begin
                queue_request(MODE_CLEAR, wide_index(), wide_index(), wide_index(),
                              $urandom_range(0, 15));
                pushed = 1;
            end
            while (pushed < PHASE_REQS)
                pushed += queue_random_item();
        end

        wait_idle();
        repeat (24) @(posedge clk);
        $display("Covered %0d requests: %0d clear, %0d mark, %0d read, %0d unused mode.",
                 accepted_count, mode_seen[MODE_CLEAR], mode_seen[MODE_MARK],
                 mode_seen[MODE_READ], mode_seen[MODE_NONE]);
        $display("Compared %0d results: %0d occupied reads, %0d leaves off grid, %0d mismatches.",
                 results_checked, occupied_reads, flagged_marks, mismatch_count);
        if (mismatch_count == 0)
            $display("voxel_block_fill_grid_unit_tb: clean");
        else
            $display("voxel_block_fill_grid_unit_tb: errors");
        $finish;
    end

    initial
    begin
        #150_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
        $display("voxel_block_fill_grid_unit_tb: errors");
        $finish;
    end

endmodule
